// File: src/cpca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpca_pkg
// Widths and helpers shared by the cell centroid/area core and its divider.
// ----------------------------------------------------------------------------
package cpca_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 12;
    localparam int AREA_BITS  = 50;

    localparam int DIFF_W = COORD_BITS + 1;        // vertex differences
    localparam int PROD_W = 2 * DIFF_W;            // signed cross terms
    localparam int CRS_W  = 2 * COORD_BITS + 2;    // absolute cross product
    localparam int CSUM_W = CRS_W + 1;             // sum of two cross products
    localparam int DEN_W  = CSUM_W + 2;            // three times the sum
    localparam int SUM_W  = COORD_BITS + 2;        // sum of up to four offsets
    localparam int HALF_W = (CRS_W + 1) / 2;       // cross product split point
    localparam int PART_W = CRS_W - HALF_W + SUM_W;
    localparam int NUM_W  = CRS_W + SUM_W + 2;     // weighted numerator
    localparam int QUO_W  = COORD_BITS;            // quotient bits
    localparam int DATA_IN_W  = 8 * COORD_BITS;
    localparam int DATA_OUT_W = ((2 * COORD_BITS + AREA_BITS + 7) / 8) * 8;

    localparam logic [DEN_W-1:0] DEN_TRI  = DEN_W'(3);
    localparam logic [DEN_W-1:0] DEN_MEAN = DEN_W'(4);

    // offset binary: coordinate plus half range, as unsigned
    function automatic logic [COORD_BITS-1:0] to_offset(input logic [COORD_BITS-1:0] v);
        to_offset = {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
    endfunction

endpackage

`default_nettype wire

// File: src/cpca_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpca_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit QUO_W bits, so the upper numerator bits seed the remainder.
// ----------------------------------------------------------------------------
module cpca_div
    import cpca_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo,
    output logic                  rem_nz
);

    logic [DEN_W-1:0] rem_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] bits_reg [QUO_W+1];
    logic [DEN_W:0]   trial [QUO_W];
    logic [DEN_W-1:0] rem_next [QUO_W];
    logic             take [QUO_W];

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            trial[k]    = {rem_reg[k], bits_reg[k][QUO_W-1]};
            take[k]     = trial[k] >= {1'b0, den_reg[k]};
            rem_next[k] = take[k] ? DEN_W'(trial[k] - {1'b0, den_reg[k]})
                                  : trial[k][DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num[QUO_W+DEN_W-1:QUO_W];
            den_reg[0]  <= den;
            bits_reg[0] <= num[QUO_W-1:0];
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k+1]  <= rem_next[k];
                bits_reg[k+1] <= {bits_reg[k][QUO_W-2:0], take[k]};
            end
            for (int k = 1; k < QUO_W; k++) begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo    = bits_reg[QUO_W];
    assign rem_nz = rem_reg[QUO_W] != '0;

endmodule

`default_nettype wire

// File: src/polygon_cell_centroid_area_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_cell_centroid_area_core
// Centroid and area of one triangle or quad mesh cell per transfer.
// ----------------------------------------------------------------------------
// Input channel s_*: tdata carries x0,y0,x1,y1,x2,y2,x3,y3 (signed Q12.12),
// tuser carries is_quad. Output channel m_*: tdata carries centroid_x,
// centroid_y and the 50-bit area with 24 fraction bits.
// From input transfer to output valid a cell passes five arithmetic
// stages (differences, cross terms, magnitudes, partial products, numerator
// select), the quotient seed register, a 24-stage quotient pipeline and the
// output register.
// Throughput is one cell per cycle while m_tready does not hold the pipeline;
// the quotient pipeline, one bit per stage, sets the depth.
// A synchronous low aresetn clears all valid bits and holds s_tready low;
// data registers keep their contents. When the receiver holds m_tready low
// with a result waiting, the whole pipeline holds and s_tready drops;
// nothing is lost or repeated.
// A quad of zero area returns the mean of its four vertices.
// ----------------------------------------------------------------------------
module polygon_cell_centroid_area_core
    import cpca_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_IN_W-1:0]  s_tdata,   // x0,y0,x1,y1,x2,y2,x3,y3
    input  wire logic                  s_tuser,   // is_quad
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_OUT_W-1:0]      m_tdata    // centroid_x,centroid_y,area,pad
);

    localparam int CB = COORD_BITS;
    localparam int DLY = QUO_W + 1;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = aresetn && en;

    // stage 1: differences and offset sums
    logic signed [CB-1:0] xi [4];
    logic signed [CB-1:0] yi [4];
    logic [SUM_W-1:0] ox [4];
    logic [SUM_W-1:0] oy [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            xi[i] = s_tdata[(2*i)*CB +: CB];
            yi[i] = s_tdata[(2*i+1)*CB +: CB];
            ox[i] = SUM_W'(to_offset(s_tdata[(2*i)*CB +: CB]));
            oy[i] = SUM_W'(to_offset(s_tdata[(2*i+1)*CB +: CB]));
        end
    end

    logic                     v1_reg, quad1_reg;
    logic signed [DIFF_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic [SUM_W-1:0]         sx1_1_reg, sx2_1_reg, sx4_1_reg;
    logic [SUM_W-1:0]         sy1_1_reg, sy2_1_reg, sy4_1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            quad1_reg <= s_tuser;
            ux_reg    <= DIFF_W'(xi[1]) - DIFF_W'(xi[0]);
            uy_reg    <= DIFF_W'(yi[1]) - DIFF_W'(yi[0]);
            vx_reg    <= DIFF_W'(xi[2]) - DIFF_W'(xi[0]);
            vy_reg    <= DIFF_W'(yi[2]) - DIFF_W'(yi[0]);
            wx_reg    <= DIFF_W'(xi[3]) - DIFF_W'(xi[0]);
            wy_reg    <= DIFF_W'(yi[3]) - DIFF_W'(yi[0]);
            sx1_1_reg <= ox[0] + ox[1] + ox[2];
            sx2_1_reg <= ox[0] + ox[2] + ox[3];
            sx4_1_reg <= ox[0] + ox[1] + ox[2] + ox[3];
            sy1_1_reg <= oy[0] + oy[1] + oy[2];
            sy2_1_reg <= oy[0] + oy[2] + oy[3];
            sy4_1_reg <= oy[0] + oy[1] + oy[2] + oy[3];
        end
    end

    // stage 2: cross terms
    logic                     v2_reg, quad2_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [SUM_W-1:0]         sx1_2_reg, sx2_2_reg, sx4_2_reg;
    logic [SUM_W-1:0]         sy1_2_reg, sy2_2_reg, sy4_2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            quad2_reg <= quad1_reg;
            pa_reg    <= PROD_W'(ux_reg) * PROD_W'(vy_reg);
            pb_reg    <= PROD_W'(uy_reg) * PROD_W'(vx_reg);
            pc_reg    <= PROD_W'(vx_reg) * PROD_W'(wy_reg);
            pd_reg    <= PROD_W'(vy_reg) * PROD_W'(wx_reg);
            sx1_2_reg <= sx1_1_reg;
            sx2_2_reg <= sx2_1_reg;
            sx4_2_reg <= sx4_1_reg;
            sy1_2_reg <= sy1_1_reg;
            sy2_2_reg <= sy2_1_reg;
            sy4_2_reg <= sy4_1_reg;
        end
    end

    // stage 3: magnitudes
    logic signed [PROD_W:0] d1, d2;
    logic [PROD_W:0]        m1, m2;

    always_comb begin
        d1 = (PROD_W+1)'(pa_reg) - (PROD_W+1)'(pb_reg);
        d2 = (PROD_W+1)'(pc_reg) - (PROD_W+1)'(pd_reg);
        m1 = d1[PROD_W] ? -d1 : d1;
        m2 = d2[PROD_W] ? -d2 : d2;
    end

    logic             v3_reg, quad3_reg;
    logic [CRS_W-1:0] c1_reg, c2_reg;
    logic [SUM_W-1:0] sx1_3_reg, sx2_3_reg, sx4_3_reg;
    logic [SUM_W-1:0] sy1_3_reg, sy2_3_reg, sy4_3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            quad3_reg <= quad2_reg;
            c1_reg    <= CRS_W'(m1);
            c2_reg    <= quad2_reg ? CRS_W'(m2) : '0;
            sx1_3_reg <= sx1_2_reg;
            sx2_3_reg <= sx2_2_reg;
            sx4_3_reg <= sx4_2_reg;
            sy1_3_reg <= sy1_2_reg;
            sy2_3_reg <= sy2_2_reg;
            sy4_3_reg <= sy4_2_reg;
        end
    end

    // stage 4: area, denominator, split partial products
    logic [CSUM_W-1:0]        csum;
    logic [CRS_W-HALF_W-1:0]  c1h, c2h;
    logic [HALF_W-1:0]        c1l, c2l;

    always_comb begin
        csum = CSUM_W'(c1_reg) + CSUM_W'(c2_reg);
        c1h  = c1_reg[CRS_W-1:HALF_W];
        c2h  = c2_reg[CRS_W-1:HALF_W];
        c1l  = c1_reg[HALF_W-1:0];
        c2l  = c2_reg[HALF_W-1:0];
    end

    logic              v4_reg, quad4_reg, zero4_reg;
    logic [CSUM_W-1:0] csum4_reg;
    logic [DEN_W-1:0]  den4_reg;
    logic [PART_W-1:0] xh1_reg, xh2_reg, yh1_reg, yh2_reg;
    logic [PART_W-1:0] xl1_reg, xl2_reg, yl1_reg, yl2_reg;
    logic [SUM_W-1:0]  sx1_4_reg, sx4_4_reg, sy1_4_reg, sy4_4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            quad4_reg <= quad3_reg;
            zero4_reg <= csum == '0;
            csum4_reg <= csum;
            den4_reg  <= DEN_W'(csum) + DEN_W'({csum, 1'b0});
            xh1_reg   <= PART_W'(c1h) * PART_W'(sx1_3_reg);
            xh2_reg   <= PART_W'(c2h) * PART_W'(sx2_3_reg);
            yh1_reg   <= PART_W'(c1h) * PART_W'(sy1_3_reg);
            yh2_reg   <= PART_W'(c2h) * PART_W'(sy2_3_reg);
            xl1_reg   <= PART_W'(c1l) * PART_W'(sx1_3_reg);
            xl2_reg   <= PART_W'(c2l) * PART_W'(sx2_3_reg);
            yl1_reg   <= PART_W'(c1l) * PART_W'(sy1_3_reg);
            yl2_reg   <= PART_W'(c2l) * PART_W'(sy2_3_reg);
            sx1_4_reg <= sx1_3_reg;
            sx4_4_reg <= sx4_3_reg;
            sy1_4_reg <= sy1_3_reg;
            sy4_4_reg <= sy4_3_reg;
        end
    end

    // stage 5: numerator and divisor select
    logic [NUM_W-1:0] wnum_x, wnum_y;
    logic [NUM_W-1:0] num_x, num_y;
    logic [DEN_W-1:0] den_sel;

    always_comb begin
        wnum_x = ((NUM_W'(xh1_reg) + NUM_W'(xh2_reg)) << HALF_W)
               + NUM_W'(xl1_reg) + NUM_W'(xl2_reg);
        wnum_y = ((NUM_W'(yh1_reg) + NUM_W'(yh2_reg)) << HALF_W)
               + NUM_W'(yl1_reg) + NUM_W'(yl2_reg);
        if (!quad4_reg) begin
            num_x   = NUM_W'(sx1_4_reg);
            num_y   = NUM_W'(sy1_4_reg);
            den_sel = DEN_TRI;
        end else if (zero4_reg) begin
            num_x   = NUM_W'(sx4_4_reg);
            num_y   = NUM_W'(sy4_4_reg);
            den_sel = DEN_MEAN;
        end else begin
            num_x   = wnum_x;
            num_y   = wnum_y;
            den_sel = den4_reg;
        end
    end

    logic                 v5_reg;
    logic [NUM_W-1:0]     num_x5_reg, num_y5_reg;
    logic [DEN_W-1:0]     den5_reg;
    logic [AREA_BITS-1:0] area5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_x5_reg <= num_x;
            num_y5_reg <= num_y;
            den5_reg   <= den_sel;
            area5_reg  <= csum4_reg[AREA_BITS:1];
        end
    end

    // quotient pipeline
    logic [QUO_W-1:0] qx, qy;
    logic             rx_nz, ry_nz;

    cpca_div u_div_x (
        .aclk   (aclk),
        .en     (en),
        .num    (num_x5_reg),
        .den    (den5_reg),
        .quo    (qx),
        .rem_nz (rx_nz)
    );

    cpca_div u_div_y (
        .aclk   (aclk),
        .en     (en),
        .num    (num_y5_reg),
        .den    (den5_reg),
        .quo    (qy),
        .rem_nz (ry_nz)
    );

    logic                 vd_reg [DLY];
    logic [AREA_BITS-1:0] ad_reg [DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            ad_reg[0] <= area5_reg;
            for (int k = 1; k < DLY; k++) begin
                ad_reg[k] <= ad_reg[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DLY; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vd_reg[0] <= v5_reg;
            for (int k = 1; k < DLY; k++) begin
                vd_reg[k] <= vd_reg[k-1];
            end
            out_valid_reg <= vd_reg[DLY-1];
        end
    end

    // output: remove offset, truncate toward zero
    logic signed [CB:0] rx, ry;
    logic [CB-1:0]      cx, cy;

    always_comb begin
        rx = (CB+1)'(qx) - (CB+1)'(1 << (CB - 1));
        ry = (CB+1)'(qy) - (CB+1)'(1 << (CB - 1));
        cx = (rx[CB] && rx_nz) ? CB'(rx + (CB+1)'(1)) : CB'(rx);
        cy = (ry[CB] && ry_nz) ? CB'(ry + (CB+1)'(1)) : CB'(ry);
    end

    logic [CB-1:0]        cx_reg, cy_reg;
    logic [AREA_BITS-1:0] area_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg   <= cx;
            cy_reg   <= cy;
            area_reg <= ad_reg[DLY-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_OUT_W'({area_reg, cy_reg, cx_reg});

endmodule

`default_nettype wire

// File: dv/polygon_cell_centroid_area_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_cell_centroid_area_core_test
// Streams triangle and quad cells through the core and checks each centroid
// and area against an exact integer prediction, under random idling, receiver
// stalls and one long back-pressure hold.
// ----------------------------------------------------------------------------
module polygon_cell_centroid_area_core_test;
    import cpca_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [AREA_BITS-1:0]  area;
    } cell_geom_t;

    class cell_scoreboard;
        cell_geom_t pending_geom[$];
        int         n_errors;
        int         n_checked;
        int         n_quads;
        int         n_degenerate;

        function automatic logic [63:0] cross_mag(longint ax, longint ay, longint bx,
                                                  longint by, longint qx, longint qy);
            longint c;
            c = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
            return (c < 0) ? -c : c;
        endfunction

        // exact area-weighted coordinate, one truncating division
        function automatic longint weighted_coord(logic [63:0] c1, logic [63:0] c2,
                                                  longint p0, longint p1, longint p2,
                                                  longint p3);
            logic signed [127:0] num, den;
            num = $signed({64'd0, c1}) * (p0 + p1 + p2)
                + $signed({64'd0, c2}) * (p0 + p2 + p3);
            den = 3 * $signed({64'd0, c1 + c2});
            return longint'(num / den);
        endfunction

        function void note_cell(logic quad, logic [DATA_IN_W-1:0] d);
            longint     v[8];
            logic [63:0] c1, c2;
            longint     cx, cy;
            cell_geom_t g;
            for (int i = 0; i < 8; i++) v[i] = longint'(coord_t'(d[i*COORD_BITS +: COORD_BITS]));
            c1 = cross_mag(v[0], v[1], v[2], v[3], v[4], v[5]);
            c2 = '0;
            if (!quad) begin
                cx = (v[0] + v[2] + v[4]) / 3;
                cy = (v[1] + v[3] + v[5]) / 3;
            end else begin
                n_quads++;
                c2 = cross_mag(v[0], v[1], v[4], v[5], v[6], v[7]);
                if (c1 + c2 != 0) begin
                    cx = weighted_coord(c1, c2, v[0], v[2], v[4], v[6]);
                    cy = weighted_coord(c1, c2, v[1], v[3], v[5], v[7]);
                end else begin
                    n_degenerate++;
                    cx = (v[0] + v[2] + v[4] + v[6]) / 4;
                    cy = (v[1] + v[3] + v[5] + v[7]) / 4;
                end
            end
            g.cx   = cx[COORD_BITS-1:0];
            g.cy   = cy[COORD_BITS-1:0];
            g.area = AREA_BITS'((c1 + c2) >> 1);
            pending_geom = {pending_geom, g};
        endfunction

        function void check_result(logic [DATA_OUT_W-1:0] d);
            cell_geom_t want;
            logic [COORD_BITS-1:0] got_cx, got_cy;
            logic [AREA_BITS-1:0]  got_area;
            got_cx   = d[0 +: COORD_BITS];
            got_cy   = d[COORD_BITS +: COORD_BITS];
            got_area = d[2*COORD_BITS +: AREA_BITS];
            if (pending_geom.size() == 0) begin
                $error("unexpected result transfer: %h", d);
                n_errors++;
                return;
            end
            want = pending_geom.pop_front();
            n_checked++;
            if (got_cx !== want.cx) begin
                $error("centroid_x expected %h actual %h", want.cx, got_cx);
                n_errors++;
            end
            if (got_cy !== want.cy) begin
                $error("centroid_y expected %h actual %h", want.cy, got_cy);
                n_errors++;
            end
            if (got_area !== want.area) begin
                $error("area expected %h actual %h", want.area, got_area);
                n_errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;

    cell_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;

    always #2 aclk = ~aclk;

    polygon_cell_centroid_area_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // x0,y0,x1,y1,x2,y2,x3,y3
        .s_tuser (s_tuser),   // is_quad
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // centroid_x,centroid_y,area,pad
    );

    // receiver: random stalls, full hold while hold_off is set
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= aresetn && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_cell(input logic quad, input logic [DATA_IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= quad;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_cell(quad, d);
    endtask

    function automatic coord_t rand_coord(int span);
        case ($urandom_range(9))
            0: return coord_t'($urandom_range(1) ? 24'h7FFFFF : 24'h800000);
            1: return coord_t'($urandom);
            default: return coord_t'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    task automatic send_random_cell();
        logic [DATA_IN_W-1:0] d;
        coord_t base_x, base_y;
        int span, shape;
        span   = $urandom_range(3) == 0 ? 8388607 : (1 << $urandom_range(4, 20));
        base_x = rand_coord(4194304);
        base_y = rand_coord(4194304);
        shape  = $urandom_range(15);
        for (int i = 0; i < 8; i++) begin
            coord_t c;
            c = (i[0] ? base_y : base_x) + rand_coord(span);
            d[i*COORD_BITS +: COORD_BITS] = c;
        end
        // collinear or coincident vertices to reach zero area
        if (shape == 0) begin
            for (int i = 2; i < 8; i++) d[i*COORD_BITS +: COORD_BITS] = d[(i%2)*COORD_BITS +: COORD_BITS];
        end else if (shape == 1) begin
            for (int k = 1; k < 4; k++) begin
                d[(2*k)*COORD_BITS +: COORD_BITS]   = base_x + coord_t'(k * 1000);
                d[(2*k+1)*COORD_BITS +: COORD_BITS] = base_y + coord_t'(k * 3000);
            end
        end
        send_cell(1'($urandom_range(1)), d);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending_geom.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int i;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero area, triangle ignoring vertex 3
        send_cell(1'b0, '0);
        send_cell(1'b1, '0);
        send_cell(1'b0, {8{24'h7FFFFF}});
        send_cell(1'b1, {8{24'h800000}});
        send_cell(1'b0, {24'h0, 24'h0, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
                         24'h800000, 24'h7FFFFF});
        send_cell(1'b1, {24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                         24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000});
        send_cell(1'b1, {24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
                         24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
        send_cell(1'b0, {24'h123456, 24'h654321, 24'h001000, 24'h000000,
                         24'h000000, 24'h001000, 24'h000000, 24'h000000});
        send_cell(1'b1, {24'h001000, 24'h000000, 24'h001000, 24'h001000,
                         24'h000000, 24'h001000, 24'h000000, 24'h000000});
        send_cell(1'b1, {24'hFFF000, 24'h000000, 24'hFFF000, 24'hFFF000,
                         24'h000000, 24'hFFF000, 24'h000000, 24'h000000});
        send_cell(1'b1, {24'h000003, 24'h000003, 24'h000002, 24'h000002,
                         24'h000001, 24'h000001, 24'hFFFFFF, 24'hFFFFFF});
        send_cell(1'b0, {24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFF,
                         24'hFFFFFF, 24'h000000, 24'h000000});
        send_cell(1'b0, {24'h0, 24'h0, 24'h000001, 24'h000002, 24'h000002,
                         24'h000001, 24'h0, 24'h0});
        send_cell(1'b1, {24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                         24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA});

        // long receiver hold while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                for (i = 0; i < 300; i++) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 60; k++) send_random_cell();
        join

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int k = 0; k < 335; k++) begin
                // short bursts without idling
                if (k % 97 == 50) begin
                    int save_s, save_r;
                    save_s = send_idle_pct;
                    save_r = recv_stall_pct;
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    repeat (20) send_random_cell();
                    send_idle_pct = save_s;
                    recv_stall_pct = save_r;
                end else begin
                    send_random_cell();
                end
            end
        end

        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        drain();
        $display("covered %0d results, %0d quads, %0d zero-area quads",
                 sb.n_checked, sb.n_quads, sb.n_degenerate);
        $display("idling phases: none, sender, receiver, both; one long receiver hold");
        if (sb.n_errors == 0 && sb.pending_geom.size() == 0) begin
            $display("polygon_cell_centroid_area_core_test: PASS");
        end else begin
            if (sb.pending_geom.size() != 0)
                $error("%0d expected results never arrived", sb.pending_geom.size());
            $display("polygon_cell_centroid_area_core_test: FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("polygon_cell_centroid_area_core_test: FAIL");
        $finish;
    end

endmodule
